// File: hdl/sorted_intercept_list_merge_assert.svh
// Assertion macros shared by the intercept list RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef SORTED_INTERCEPT_LIST_MERGE_ASSERT_SVH
`define SORTED_INTERCEPT_LIST_MERGE_ASSERT_SVH

// Same-cycle implication.
`define SILM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SILM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/silm_pkg.sv
package silm_pkg;

    localparam int LIST_DEPTH = 32;
    localparam int LEN_W      = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int DIST_W     = 32;
    localparam int ID_W       = 16;
    localparam int GAP_W      = 16;
    localparam int COUNT_W    = 6;

    localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(51);

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_MERGE  = 2'd2,
        ACT_READ   = 2'd3
    } action_t;

    typedef struct packed {
        logic signed [DIST_W-1:0] distance;
        logic                     bvalid;
        logic [ID_W-1:0]          bid;
        logic                     avalid;
        logic [ID_W-1:0]          aid;
        logic                     self_ref;
    } entry_t;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic             ins;
        logic             fold;
        logic             rot;
        logic [LEN_W-1:0] len;
        entry_t           load_e;
    } cell_cmd_t;

    typedef struct packed {
        entry_t             e;
        logic               entry_valid;
        logic [COUNT_W-1:0] count;
        logic               overflow;
        logic               last;
    } result_t;

    // Folds the later entry b into the earlier entry a; a keeps its distance.
    function automatic entry_t fold_entries(entry_t a, entry_t b);
        entry_t r;
        r = a;
        if (a.self_ref && !b.self_ref) begin
            if (a.bvalid && b.bvalid) begin
                r.bid = b.bid;
            end
            if (a.avalid && b.avalid) begin
                r.aid = b.aid;
            end
            r.self_ref = 1'b0;
        end
        if (!r.bvalid && b.bvalid) begin
            r.bvalid = 1'b1;
            r.bid    = b.bid;
        end
        if (!r.avalid && b.avalid) begin
            r.avalid = 1'b1;
            r.aid    = b.aid;
        end
        return r;
    endfunction

endpackage

// File: hdl/sorted_intercept_list_merge.sv
// Channel  Direction  Handshake              Contents
// s_axis   in         s_axis_tvalid/tready   tuser: action; tdata: one intercept
// m_axis   out        m_axis_tvalid/tready   tuser: entry flag, overflow; tdata: entry, count
// cfg      in         cfg_valid/cfg_ready    merge gap (Q8.8, unsigned)
//
// Clear and insert each give one status result; a new one is taken every cycle the result is drained.
// Merge walks the list with one compare-and-fold or rotate step per list entry through
// cell 0 and cell 1, then gives the status result. Read gives one entry per cycle while m_axis takes them.
// Reset (rst_n, asynchronous) empties the list and restores the merge gap to 51 (0.2).
// A stalled m_axis holds read walks in place; no input is taken while a walk is running.
module sorted_intercept_list_merge
    import silm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // [1:0] action
    input  logic [1:0]       s_axis_tuser,
    // [31:0] distance, [32] before_valid, [48:33] before_id, [49] after_valid,
    // [65:50] after_id, [66] self_ref, [71:67] zero fill
    input  logic [71:0]      s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // [31:0] out_distance, [32] out_before_valid, [48:33] out_before_id,
    // [49] out_after_valid, [65:50] out_after_id, [66] out_self_ref,
    // [72:67] entry_count, [79:73] zero fill
    output logic [79:0]      m_axis_tdata,
    // [0] entry_valid, [1] overflow
    output logic [1:0]       m_axis_tuser,
    output logic             m_axis_tlast,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [GAP_W-1:0] cfg_data
);

    entry_t    item;
    cell_cmd_t cmd;
    result_t   res;
    entry_t    cell_e  [LIST_DEPTH];
    logic      cell_gt [LIST_DEPTH];

    // Unpack the incoming transaction into one list entry.
    always_comb
    begin
        item.distance = s_axis_tdata[31:0];
        item.bvalid   = s_axis_tdata[32];
        item.bid      = s_axis_tdata[48:33];
        item.avalid   = s_axis_tdata[49];
        item.aid      = s_axis_tdata[65:50];
        item.self_ref = s_axis_tdata[66];
    end

    silm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .action    (action_t'(s_axis_tuser)),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .head_e    (cell_e[0]),
        .second_e  (cell_e[1]),
        .cmd       (cmd),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    // The chain: cell 0 is always the list head during a walk, and every cell sees
    // its two neighbors, so inserts shift right and walks rotate left.
    for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
        entry_t prev_e;
        logic   prev_gt;
        entry_t next_e;

        if (i == 0) begin : g_first
            assign prev_e  = '0;
            assign prev_gt = 1'b0;
        end else begin : g_mid
            assign prev_e  = cell_e[i-1];
            assign prev_gt = cell_gt[i-1];
        end

        if (i == LIST_DEPTH - 1) begin : g_last
            assign next_e = '0;
        end else begin : g_body
            assign next_e = cell_e[i+1];
        end

        silm_cell u_cell
        (
            .clk     (clk),
            .idx     (IDX_W'(i)),
            .cmd     (cmd),
            .prev_e  (prev_e),
            .prev_gt (prev_gt),
            .next_e  (next_e),
            .head_e  (cell_e[0]),
            .e       (cell_e[i]),
            .gt      (cell_gt[i])
        );
    end

    // Pack the result transaction.
    assign m_axis_tdata = {7'b0, res.count, res.e.self_ref, res.e.aid, res.e.avalid,
                           res.e.bid, res.e.bvalid, res.e.distance};
    assign m_axis_tuser = {res.overflow, res.entry_valid};
    assign m_axis_tlast = res.last;

endmodule

// File: hdl/silm_cell.sv
// One list slot. Cells shift right on insert and left on merge or rotation.
module silm_cell
    import silm_pkg::*;
(
    input  logic             clk,
    input  logic [IDX_W-1:0] idx,
    input  cell_cmd_t        cmd,
    input  entry_t           prev_e,
    input  logic             prev_gt,
    input  entry_t           next_e,
    input  entry_t           head_e,
    output entry_t           e,
    output logic             gt
);

    entry_t           e_reg;
    entry_t           e_next;
    logic [LEN_W-1:0] pos;
    logic [LEN_W-1:0] pos1;

    assign pos  = LEN_W'(idx);
    assign pos1 = pos + LEN_W'(1);

    // This occupied slot lies strictly after the new entry.
    assign gt = (pos < cmd.len) && (cmd.load_e.distance < e_reg.distance);
    assign e  = e_reg;

    always_comb
    begin
        e_next = e_reg;
        if (cmd.ins) begin
            if (pos <= cmd.len) begin
                if (prev_gt) begin
                    e_next = prev_e;
                end else if (gt || pos == cmd.len) begin
                    e_next = cmd.load_e;
                end
            end
        end else if (cmd.fold) begin
            if (pos == '0) begin
                e_next = cmd.load_e;
            end else if (pos1 < cmd.len) begin
                e_next = next_e;
            end
        end else if (cmd.rot) begin
            if (pos1 < cmd.len) begin
                e_next = next_e;
            end else if (pos1 == cmd.len) begin
                e_next = head_e;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg <= e_next;
    end

endmodule

// File: hdl/silm_ctrl.sv
`include "sorted_intercept_list_merge_assert.svh"

// Sequencer: list length, merge/read walk counter, gap register, result register.
module silm_ctrl
    import silm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_valid,
    output logic             s_ready,
    input  action_t          action,
    input  entry_t           item,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [GAP_W-1:0] cfg_data,
    input  entry_t           head_e,
    input  entry_t           second_e,
    output cell_cmd_t        cmd,
    output logic             out_valid,
    input  logic             out_ready,
    output result_t          out_res
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_MERGE = 3'b010,
        ST_READ  = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LEN_W-1:0]   rem_reg, rem_next;
    logic [GAP_W-1:0]   gap_reg;
    logic               out_valid_reg, out_valid_next;
    result_t            res_reg, res_next;
    logic               out_free;
    logic               accept;
    logic               close;
    logic signed [DIST_W:0] gap_diff;
    logic signed [DIST_W:0] gap_lim;

    assign out_free  = !out_valid_reg || out_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    assign gap_diff = {second_e.distance[DIST_W-1], second_e.distance}
                    - {head_e.distance[DIST_W-1], head_e.distance};
    assign gap_lim  = $signed((DIST_W+1)'(gap_reg));
    assign close    = gap_diff <= gap_lim;

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg && !out_ready;
        res_next       = res_reg;
        cmd            = '0;
        cmd.len        = len_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    res_next             = '0;
                    res_next.last        = 1'b1;
                    case (action)
                        ACT_CLEAR:
                        begin
                            len_next       = '0;
                            out_valid_next = 1'b1;
                        end
                        ACT_INSERT:
                        begin
                            if (len_reg == LEN_W'(LIST_DEPTH)) begin
                                res_next.overflow = 1'b1;
                            end else begin
                                cmd.ins    = 1'b1;
                                cmd.load_e = item;
                                len_next   = len_reg + LEN_W'(1);
                            end
                            out_valid_next = 1'b1;
                        end
                        ACT_MERGE:
                        begin
                            rem_next   = len_reg;
                            state_next = ST_MERGE;
                        end
                        ACT_READ:
                        begin
                            if (len_reg == '0) begin
                                out_valid_next = 1'b1;
                            end else begin
                                rem_next   = len_reg;
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                    res_next.count = COUNT_W'(len_next);
                end
            end
            ST_MERGE:
            begin
                if (rem_reg > LEN_W'(1)) begin
                    rem_next = rem_reg - LEN_W'(1);
                    if (close) begin
                        cmd.fold   = 1'b1;
                        cmd.load_e = fold_entries(head_e, second_e);
                        len_next   = len_reg - LEN_W'(1);
                    end else begin
                        cmd.rot = 1'b1;
                    end
                end else if (rem_reg == LEN_W'(1)) begin
                    // The last unvisited entry goes to the tail, restoring order.
                    cmd.rot  = 1'b1;
                    rem_next = '0;
                end else if (out_free) begin
                    res_next       = '0;
                    res_next.last  = 1'b1;
                    res_next.count = COUNT_W'(len_reg);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_READ:
            begin
                if (out_free) begin
                    res_next.e           = head_e;
                    res_next.entry_valid = 1'b1;
                    res_next.count       = COUNT_W'(len_reg);
                    res_next.overflow    = 1'b0;
                    res_next.last        = (rem_reg == LEN_W'(1));
                    out_valid_next       = 1'b1;
                    cmd.rot              = 1'b1;
                    rem_next             = rem_reg - LEN_W'(1);
                    if (rem_reg == LEN_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            rem_reg       <= '0;
            gap_reg       <= GAP_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                gap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    `SILM_ASSERT_NOW(a_len_bound, 1'b1, len_reg <= LEN_W'(LIST_DEPTH), "list length past depth")
    `SILM_ASSERT_NOW(a_rem_bound, state_reg != ST_IDLE, rem_reg <= len_reg, "walk past list end")
    `SILM_ASSERT_NOW(a_idle_rem, state_reg == ST_IDLE, rem_reg == '0, "walk left unfinished")
    `SILM_ASSERT_NEXT(a_ins_grow, accept && action == ACT_INSERT && len_reg != LEN_W'(LIST_DEPTH), len_reg == $past(len_reg) + LEN_W'(1), "insert did not grow list")

endmodule

// File: test/sorted_intercept_list_merge_tb.sv
module sorted_intercept_list_merge_tb;

    import silm_pkg::*;

    // Stop the run if it is still going after this many clock cycles.
    localparam int unsigned CYCLE_LIMIT = 200000;
    // Number of random transactions sent after the directed part.
    localparam int unsigned RANDOM_ITEMS = 320;
    // Length of the long output stall that forces the block to back up.
    localparam int unsigned SINK_HOLD_CYCLES = 400;

    // Mirror of the intercept list. Every accepted input transaction is applied
    // to the mirror, and the results it must produce are queued in order.
    class intercept_list_scoreboard;
        entry_t           slots[LIST_DEPTH];
        int unsigned      used;
        logic [GAP_W-1:0] merge_gap;
        result_t          pending_results[$];
        int unsigned      errors;

        function new();
            used      = 0;
            merge_gap = GAP_RESET;
            errors    = 0;
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        function void push_status(logic overflow);
            result_t r;
            r          = '0;
            r.count    = used[COUNT_W-1:0];
            r.overflow = overflow;
            r.last     = 1'b1;
            pending_results.push_back(r);
        endfunction

        // The later entry b is folded into the earlier entry a.
        function entry_t fold_later_into(entry_t a, entry_t b);
            entry_t m;
            m = a;
            if (a.self_ref && !b.self_ref) begin
                if (a.bvalid && b.bvalid) begin
                    m.bid = b.bid;
                end
                if (a.avalid && b.avalid) begin
                    m.aid = b.aid;
                end
                m.self_ref = 1'b0;
            end
            if (!m.bvalid && b.bvalid) begin
                m.bvalid = 1'b1;
                m.bid    = b.bid;
            end
            if (!m.avalid && b.avalid) begin
                m.avalid = 1'b1;
                m.aid    = b.aid;
            end
            return m;
        endfunction

        function logic insert_sorted(entry_t e);
            int unsigned pos;
            if (used >= LIST_DEPTH) begin
                return 1'b1;
            end
            pos = used;
            while (pos > 0 && $signed(e.distance) < $signed(slots[pos-1].distance)) begin
                pos--;
            end
            for (int unsigned i = used; i > pos; i--) begin
                slots[i] = slots[i-1];
            end
            slots[pos] = e;
            used++;
            return 1'b0;
        endfunction

        function void merge_neighbors();
            int unsigned cur;
            longint      step;
            cur = 0;
            while (cur + 1 < used) begin
                step = longint'($signed(slots[cur+1].distance))
                     - longint'($signed(slots[cur].distance));
                if (step > longint'(merge_gap)) begin
                    cur++;
                end
                else begin
                    slots[cur] = fold_later_into(slots[cur], slots[cur+1]);
                    for (int unsigned i = cur + 1; i + 1 < used; i++) begin
                        slots[i] = slots[i+1];
                    end
                    used--;
                end
            end
        endfunction

        // Applies one accepted command and queues the results it causes.
        function void take_command(action_t act, entry_t e);
            result_t r;
            logic    dropped;
            case (act)
                ACT_CLEAR: begin
                    used = 0;
                    push_status(1'b0);
                end
                ACT_INSERT: begin
                    dropped = insert_sorted(e);
                    push_status(dropped);
                end
                ACT_MERGE: begin
                    merge_neighbors();
                    push_status(1'b0);
                end
                default: begin
                    if (used == 0) begin
                        push_status(1'b0);
                    end
                    for (int unsigned k = 0; k < used; k++) begin
                        r             = '0;
                        r.e           = slots[k];
                        r.entry_valid = 1'b1;
                        r.count       = used[COUNT_W-1:0];
                        r.last        = (k + 1 == used);
                        pending_results.push_back(r);
                    end
                end
            endcase
        endfunction

        function void compare_field(string field, longint unsigned want, longint unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, field, want, got);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected, expected none, actual distance 0x%0h",
                         $time, got.e.distance);
                return;
            end
            want = pending_results.pop_front();
            compare_field("distance", want.e.distance, got.e.distance);
            compare_field("before_valid", want.e.bvalid, got.e.bvalid);
            compare_field("before_id", want.e.bid, got.e.bid);
            compare_field("after_valid", want.e.avalid, got.e.avalid);
            compare_field("after_id", want.e.aid, got.e.aid);
            compare_field("self_ref", want.e.self_ref, got.e.self_ref);
            compare_field("entry_valid", want.entry_valid, got.entry_valid);
            compare_field("entry_count", want.count, got.count);
            compare_field("overflow", want.overflow, got.overflow);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [1:0]       s_axis_tuser = '0;
    logic [71:0]      s_axis_tdata = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [79:0]      m_axis_tdata;
    logic [1:0]       m_axis_tuser;
    logic             m_axis_tlast;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [GAP_W-1:0] cfg_data = '0;

    intercept_list_scoreboard book = new();

    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    int unsigned random_sent = 0;
    bit          counting_random = 1'b0;
    bit          sender_gaps_on = 1'b1;
    bit          hold_request = 1'b0;

    sorted_intercept_list_merge dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // Watchdog: a run that hangs is a failure.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Every output transaction is unpacked and checked against the oldest expectation.
    always @(posedge clk) begin
        result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got.e.distance  = m_axis_tdata[31:0];
            got.e.bvalid    = m_axis_tdata[32];
            got.e.bid       = m_axis_tdata[48:33];
            got.e.avalid    = m_axis_tdata[49];
            got.e.aid       = m_axis_tdata[65:50];
            got.e.self_ref  = m_axis_tdata[66];
            got.count       = m_axis_tdata[72:67];
            got.entry_valid = m_axis_tuser[0];
            got.overflow    = m_axis_tuser[1];
            got.last        = m_axis_tlast;
            book.check_result(got);
        end
    end

    // The output side picks its own stall pattern every so often. On request it
    // also holds off for a long stretch so that the block backs up into its input.
    initial begin : result_sink
        int unsigned mode;
        int unsigned mode_left;
        int unsigned hold_left;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = SINK_HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else begin
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= ($urandom_range(0, 7) != 0);
                    default: m_axis_tready <= (mode_left % 4 == 0);
                endcase
            end
        end
    end

    function automatic entry_t make_entry(logic [31:0] distance, logic bvalid, logic [15:0] bid,
                                          logic avalid, logic [15:0] aid, logic self_ref);
        entry_t e;
        e.distance = distance;
        e.bvalid   = bvalid;
        e.bid      = bid;
        e.avalid   = avalid;
        e.aid      = aid;
        e.self_ref = self_ref;
        return e;
    endfunction

    function automatic entry_t random_entry();
        return make_entry($urandom, 1'($urandom_range(0, 1)),
                          16'($urandom_range(0, 16'hFFFF)),
                          1'($urandom_range(0, 1)), 16'($urandom_range(0, 16'hFFFF)),
                          1'($urandom_range(0, 1)));
    endfunction

    // Offers one command and waits for it to be taken. The sender works in bursts;
    // between bursts it may drop valid for a random number of cycles.
    task automatic send_item(input action_t act, input entry_t e);
        int unsigned pause;
        if (burst_left == 0) begin
            pause = sender_gaps_on ? $urandom_range(0, 8) : 0;
            if (pause != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {5'b0, e.self_ref, e.aid, e.avalid, e.bid, e.bvalid, e.distance};
        do begin
            @(posedge clk);
        end while (!s_axis_tready);
        book.take_command(act, e);
        if (counting_random) begin
            random_sent++;
        end
    endtask

    // Stops sending and waits until every expected result has come back, then
    // leaves room for a merge walk that may still be finishing.
    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (book.pending() != 0) begin
            @(posedge clk);
        end
        repeat (LIST_DEPTH + 4) @(posedge clk);
    endtask

    task automatic write_merge_gap(input logic [GAP_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do begin
            @(posedge clk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        book.merge_gap = value;
    endtask

    // Directed checks at the default gap of 51 (0.2 in Q8.8).
    task automatic run_directed();
        // Read and merge of an empty list, then merge of a single entry.
        send_item(ACT_READ, random_entry());
        send_item(ACT_MERGE, random_entry());
        send_item(ACT_INSERT, make_entry(32'h100, 1'b1, 16'hFFFF, 1'b0, 16'h0, 1'b1));
        send_item(ACT_MERGE, random_entry());
        // Both ends of the distance range and all-zero and all-one side data.
        send_item(ACT_INSERT, make_entry(32'h8000_0000, 1'b0, 16'h0, 1'b0, 16'h0, 1'b0));
        send_item(ACT_INSERT, make_entry(32'h7FFF_FFFF, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1));
        // Equal distance goes after the existing entry. On merge the self-referencing
        // head takes the other's ids and loses its flag.
        send_item(ACT_INSERT, make_entry(32'h100, 1'b1, 16'h1234, 1'b1, 16'h5678, 1'b0));
        // Exactly at the gap merges; one step beyond it does not, measured from the head.
        send_item(ACT_INSERT, make_entry(32'h133, 1'b0, 16'h0, 1'b1, 16'hAAAA, 1'b1));
        send_item(ACT_INSERT, make_entry(32'h134, 1'b1, 16'h5555, 1'b0, 16'h0, 1'b0));
        // Two self-referencing neighbors: the head keeps its flag and its sides.
        send_item(ACT_INSERT, make_entry(32'h0, 1'b1, 16'h0001, 1'b1, 16'h0002, 1'b1));
        send_item(ACT_INSERT, make_entry(32'h10, 1'b1, 16'h0003, 1'b0, 16'h0, 1'b1));
        send_item(ACT_READ, random_entry());
        send_item(ACT_MERGE, random_entry());
        send_item(ACT_READ, random_entry());
        send_item(ACT_CLEAR, random_entry());
        send_item(ACT_READ, random_entry());
        // A plain head with no sides picks up both sides of a self-referencing neighbor.
        send_item(ACT_INSERT, make_entry(32'hFFFF_FFFF, 1'b0, 16'h0, 1'b0, 16'h0, 1'b0));
        send_item(ACT_INSERT, make_entry(32'hFFFF_FFFF, 1'b1, 16'h0F0F, 1'b1, 16'hF0F0, 1'b1));
        send_item(ACT_MERGE, random_entry());
        send_item(ACT_READ, random_entry());
    endtask

    // A clustered run of inserts with merges and reads mixed in, ending in a
    // merge and a read so that the folded list is always seen.
    task automatic run_list_phase(input int unsigned inserts);
        logic [31:0] base;
        int unsigned spread;
        int unsigned pick;
        entry_t      e;
        if ($urandom_range(0, 3) != 0) begin
            send_item(ACT_CLEAR, random_entry());
        end
        case ($urandom_range(0, 3))
            0:       base = 32'h7FFF_F000;
            1:       base = 32'h8000_0000;
            2:       base = 32'h0;
            default: base = $urandom;
        endcase
        case ($urandom_range(0, 4))
            0:       spread = 0;
            1:       spread = 32'(book.merge_gap);
            2:       spread = 2 * book.merge_gap + 2;
            3:       spread = 8 * book.merge_gap + 8;
            default: spread = 32'hFFFF_FFFF;
        endcase
        for (int unsigned i = 0; i < inserts; i++) begin
            e          = random_entry();
            e.distance = base + $urandom_range(0, spread);
            send_item(ACT_INSERT, e);
            pick = $urandom_range(0, 11);
            if (pick == 0) begin
                send_item(ACT_MERGE, random_entry());
            end
            else if (pick == 1) begin
                send_item(ACT_READ, random_entry());
            end
        end
        send_item(ACT_MERGE, random_entry());
        send_item(ACT_READ, random_entry());
    endtask

    initial begin : stimulus
        int unsigned      phase;
        int unsigned      inserts;
        logic [GAP_W-1:0] gap_pick;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();

        counting_random = 1'b1;
        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            // Every phase starts from an idle block with a new merge gap.
            wait_until_drained();
            case (phase)
                0:       gap_pick = '0;
                1:       gap_pick = '1;
                2:       gap_pick = GAP_RESET;
                default: gap_pick = ($urandom_range(0, 1) != 0)
                                    ? GAP_W'($urandom_range(0, 16'hFFFF))
                                    : GAP_W'($urandom_range(0, 300));
            endcase
            write_merge_gap(gap_pick);
            sender_gaps_on = (phase % 4 != 3);
            if (phase == 2) begin
                // Long output stall with the sender pushing back to back.
                hold_request   = 1'b1;
                sender_gaps_on = 1'b0;
            end
            if (phase % 6 == 5) begin
                // Noise: random commands with random content.
                repeat ($urandom_range(8, 20)) begin
                    send_item(action_t'($urandom_range(0, 3)), random_entry());
                end
            end
            else begin
                inserts = (phase % 7 == 4) ? LIST_DEPTH + 3 : $urandom_range(2, 14);
                if (phase == 2) begin
                    inserts = 20;
                end
                run_list_phase(inserts);
            end
            phase++;
        end

        wait_until_drained();
        if (book.errors == 0 && book.pending() == 0) begin
            $display("RESULT: OK");
        end
        else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
